// ===== sv/assert_macros.svh =====
// assertion helpers used by apd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is applied
`define APD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("apd check failed");

// next-cycle implication, quiet while reset is applied
`define APD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("apd check failed");

`endif

// ===== sv/apd_pkg.sv =====
`default_nettype none

package apd_pkg;

	// field widths
	localparam int ID_W       = 10;
	localparam int PORT_W     = 16;
	localparam int LEN_W      = 16;
	localparam int HEAD_W     = 48;
	localparam int PROTO_W    = 3;
	localparam int CONF_W     = 7;
	localparam int ATT_W      = 4;
	localparam int DS_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = $clog2(ID_W + 1);
	localparam int NUM_PROTO  = 6;

	localparam int SESSIONS_DEFAULT = 1024;

	// protocol codes
	localparam logic [PROTO_W-1:0] PROTO_UNKNOWN = 3'd0;
	localparam logic [PROTO_W-1:0] PROTO_HTTP    = 3'd1;
	localparam logic [PROTO_W-1:0] PROTO_FTP     = 3'd2;
	localparam logic [PROTO_W-1:0] PROTO_SMTP    = 3'd3;
	localparam logic [PROTO_W-1:0] PROTO_TLS     = 3'd4;
	localparam logic [PROTO_W-1:0] PROTO_SSH     = 3'd5;
	localparam logic [PROTO_W-1:0] PROTO_DNS     = 3'd6;

	// detection state codes
	localparam logic [DS_W-1:0] DS_NONE     = 2'd0;
	localparam logic [DS_W-1:0] DS_PROGRESS = 2'd1;
	localparam logic [DS_W-1:0] DS_DONE     = 2'd2;
	localparam logic [DS_W-1:0] DS_FAILED   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HTTP_PORT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TLS_PORT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SSH_PORT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DNS_PORT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FTP_PORT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMTP_PORT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd6;

	// register reset values
	localparam logic [PORT_W-1:0] HTTP_PORT_RST     = 16'd80;
	localparam logic [PORT_W-1:0] TLS_PORT_RST      = 16'd443;
	localparam logic [PORT_W-1:0] SSH_PORT_RST      = 16'd22;
	localparam logic [PORT_W-1:0] DNS_PORT_RST      = 16'd53;
	localparam logic [PORT_W-1:0] FTP_PORT_RST      = 16'd21;
	localparam logic [PORT_W-1:0] SMTP_PORT_RST     = 16'd25;
	localparam logic [ATT_W-1:0]  ATTEMPT_LIMIT_RST = 4'd10;

	// confidence values
	localparam logic [CONF_W-1:0] CONF_STRONG  = 7'd95;
	localparam logic [CONF_W-1:0] CONF_TLS_HS  = 7'd90;
	localparam logic [CONF_W-1:0] CONF_TLS_APP = 7'd85;
	localparam logic [CONF_W-1:0] CONF_CMD     = 7'd80;
	localparam logic [CONF_W-1:0] CONF_REPLY   = 7'd70;
	localparam logic [CONF_W-1:0] CONF_DNS     = 7'd70;
	localparam logic [CONF_W-1:0] HINT_BONUS   = 7'd10;
	localparam logic [CONF_W-1:0] CONF_MAX     = 7'd100;
	localparam logic [CONF_W-1:0] CONF_DONE    = 7'd90;

	// payload signatures
	localparam logic [31:0] SIG_GET  = "GET ";
	localparam logic [31:0] SIG_POST = "POST";
	localparam logic [31:0] SIG_HEAD = "HEAD";
	localparam logic [31:0] SIG_PUT  = "PUT ";
	localparam logic [39:0] SIG_HTTP = "HTTP/";
	localparam logic [31:0] SIG_USER = "USER";
	localparam logic [31:0] SIG_PASS = "PASS";
	localparam logic [31:0] SIG_LIST = "LIST";
	localparam logic [31:0] SIG_HELO = "HELO";
	localparam logic [31:0] SIG_EHLO = "EHLO";
	localparam logic [31:0] SIG_MAIL = "MAIL";
	localparam logic [31:0] SIG_RCPT = "RCPT";
	localparam logic [31:0] SIG_SSH  = "SSH-";
	localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
	localparam logic [7:0]  TLS_APPDATA   = 8'h17;
	localparam logic [7:0]  TLS_MAJOR     = 8'h03;
	localparam logic [7:0]  TLS_MINOR_MAX = 8'h03;
	localparam logic [7:0]  CH_0 = "0";
	localparam logic [7:0]  CH_1 = "1";
	localparam logic [7:0]  CH_2 = "2";
	localparam logic [7:0]  CH_5 = "5";
	localparam logic [7:0]  CH_9 = "9";
	localparam logic [15:0] DNS_QD_MAX  = 16'd9;
	localparam logic [LEN_W-1:0] DNS_MIN_LEN = 16'd12;

	// one session entry
	typedef struct packed {
		logic [PROTO_W-1:0] proto;
		logic [CONF_W-1:0]  conf;
		logic [ATT_W-1:0]   attempts;
		logic [DS_W-1:0]    st;
	} apd_entry_t;

	// configuration register file
	typedef struct packed {
		logic [PORT_W-1:0] http_port;
		logic [PORT_W-1:0] tls_port;
		logic [PORT_W-1:0] ssh_port;
		logic [PORT_W-1:0] dns_port;
		logic [PORT_W-1:0] ftp_port;
		logic [PORT_W-1:0] smtp_port;
		logic [ATT_W-1:0]  attempt_limit;
	} apd_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic in_load;
		logic clr_wr;
		logic mod_step;
		logic rd_en;
		logic score_load;
		logic commit;
	} apd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic mod_need;
		logic mod_last;
		logic out_free;
	} apd_sts_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_EVAL
	} apd_state_t;

endpackage

`default_nettype wire

// ===== sv/apd_probe.sv =====
`default_nettype none

module apd_probe import apd_pkg::*; (
	input  logic [HEAD_W-1:0]  head,
	input  logic [LEN_W-1:0]   len,
	input  logic               dir,
	input  logic [PORT_W-1:0]  hport,
	input  apd_cfg_t           cfg,
	output logic [CONF_W-1:0]  best_conf,
	output logic [PROTO_W-1:0] win_proto
);

	logic [7:0]         b0, b1, b2;
	logic [31:0]        w4;
	logic [15:0]        qd;
	logic [PROTO_W-1:0] hint;
	logic [CONF_W-1:0]  raw [NUM_PROTO];
	logic [CONF_W-1:0]  sc  [NUM_PROTO];
	logic               len3, len4, len5;
	logic               dig_lo_tail;

	function automatic logic [CONF_W-1:0] with_bonus(input logic [CONF_W-1:0] c);
		logic [CONF_W-1:0] s;
		s = c + HINT_BONUS;
		return (s > CONF_MAX) ? CONF_MAX : s;
	endfunction

	assign b0 = head[47:40];
	assign b1 = head[39:32];
	assign b2 = head[31:24];
	assign w4 = head[47:16];
	assign qd = head[15:0];

	assign len3 = (len >= 16'd3);
	assign len4 = (len >= 16'd4);
	assign len5 = (len >= 16'd5);
	assign dig_lo_tail = (b1 >= CH_0) && (b1 <= CH_9) && (b2 >= CH_0) && (b2 <= CH_9);

	// hint port lookup, later registers take priority
	always_comb begin
		if (hport == '0) begin
			hint = PROTO_UNKNOWN;
		end else if (hport == cfg.smtp_port) begin
			hint = PROTO_SMTP;
		end else if (hport == cfg.ftp_port) begin
			hint = PROTO_FTP;
		end else if (hport == cfg.dns_port) begin
			hint = PROTO_DNS;
		end else if (hport == cfg.ssh_port) begin
			hint = PROTO_SSH;
		end else if (hport == cfg.tls_port) begin
			hint = PROTO_TLS;
		end else if (hport == cfg.http_port) begin
			hint = PROTO_HTTP;
		end else begin
			hint = PROTO_UNKNOWN;
		end
	end

	// signature probes
	always_comb begin
		// http
		if ((len4 && (w4 == SIG_GET || w4 == SIG_POST || w4 == SIG_HEAD || w4 == SIG_PUT))
				|| (len5 && head[47:8] == SIG_HTTP)) begin
			raw[0] = CONF_STRONG;
		end else begin
			raw[0] = '0;
		end
		// ftp
		if (dir && len3 && b0 >= CH_1 && b0 <= CH_5 && dig_lo_tail) begin
			raw[1] = CONF_REPLY;
		end else if (!dir && len4 && (w4 == SIG_USER || w4 == SIG_PASS || w4 == SIG_LIST)) begin
			raw[1] = CONF_CMD;
		end else begin
			raw[1] = '0;
		end
		// smtp
		if (len4 && !dir
				&& (w4 == SIG_HELO || w4 == SIG_EHLO || w4 == SIG_MAIL || w4 == SIG_RCPT)) begin
			raw[2] = CONF_CMD;
		end else if (len4 && dir && b0 >= CH_2 && b0 <= CH_5 && dig_lo_tail) begin
			raw[2] = CONF_REPLY;
		end else begin
			raw[2] = '0;
		end
		// tls
		if (len3 && b1 == TLS_MAJOR && b2 <= TLS_MINOR_MAX && b0 == TLS_HANDSHAKE) begin
			raw[3] = CONF_TLS_HS;
		end else if (len3 && b1 == TLS_MAJOR && b2 <= TLS_MINOR_MAX && b0 == TLS_APPDATA) begin
			raw[3] = CONF_TLS_APP;
		end else begin
			raw[3] = '0;
		end
		// ssh
		raw[4] = (len4 && w4 == SIG_SSH) ? CONF_STRONG : '0;
		// dns question count
		raw[5] = (len >= DNS_MIN_LEN && qd != '0 && qd <= DNS_QD_MAX) ? CONF_DNS : '0;
	end

	// port bonus and pick of the best, earlier protocol wins ties
	always_comb begin
		best_conf = '0;
		win_proto = PROTO_UNKNOWN;
		for (int p = 0; p < NUM_PROTO; p++) begin
			sc[p] = (hint == PROTO_W'(p + 1)) ? with_bonus(raw[p]) : raw[p];
			if (sc[p] > best_conf) begin
				best_conf = sc[p];
				win_proto = PROTO_W'(p + 1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/apd_regs.sv =====
`default_nettype none

module apd_regs import apd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output apd_cfg_t              cfg
);

	apd_cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.http_port     <= HTTP_PORT_RST;
			cfg_q.tls_port      <= TLS_PORT_RST;
			cfg_q.ssh_port      <= SSH_PORT_RST;
			cfg_q.dns_port      <= DNS_PORT_RST;
			cfg_q.ftp_port      <= FTP_PORT_RST;
			cfg_q.smtp_port     <= SMTP_PORT_RST;
			cfg_q.attempt_limit <= ATTEMPT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HTTP_PORT:     cfg_q.http_port     <= cfg_data;
				REG_TLS_PORT:      cfg_q.tls_port      <= cfg_data;
				REG_SSH_PORT:      cfg_q.ssh_port      <= cfg_data;
				REG_DNS_PORT:      cfg_q.dns_port      <= cfg_data;
				REG_FTP_PORT:      cfg_q.ftp_port      <= cfg_data;
				REG_SMTP_PORT:     cfg_q.smtp_port     <= cfg_data;
				REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= cfg_data[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/apd_ctrl.sv =====
`default_nettype none

module apd_ctrl import apd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  apd_sts_t sts,
	output apd_cmd_t cmd
);

	apd_state_t state_q, state_d;

	// state register, starts with the table clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d = sts.mod_need ? ST_MOD : ST_READ;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en      = 1'b1;
				cmd.score_load = 1'b1;
				state_d        = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/apd_dp.sv =====
`default_nettype none

module apd_dp import apd_pkg::*; #(
	parameter int SESSIONS = SESSIONS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  apd_cmd_t           cmd,
	output apd_sts_t           sts,
	input  apd_cfg_t           cfg,
	input  logic [ID_W-1:0]    session_id,
	input  logic [PORT_W-1:0]  source_port,
	input  logic [PORT_W-1:0]  dest_port,
	input  logic               direction,
	input  logic [LEN_W-1:0]   payload_size,
	input  logic [HEAD_W-1:0]  payload_head,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PROTO_W-1:0] protocol,
	output logic [CONF_W-1:0]  confidence,
	output logic [DS_W-1:0]    detect_state
);

	localparam int SIDX_W    = $clog2(SESSIONS);
	localparam int ID_MAX    = (1 << ID_W) - 1;
	localparam int MOD_STEPS = (SESSIONS > ID_MAX) ? 0 : $clog2(ID_MAX / SESSIONS + 1);
	localparam int DIV_INIT  = (SESSIONS << MOD_STEPS) >> 1;

	// packet registers
	logic [ID_W-1:0]    rem_q;
	logic [ID_W-1:0]    div_q;
	logic [STEP_W-1:0]  step_q;
	logic [PORT_W-1:0]  hport_q;
	logic               dir_q;
	logic [LEN_W-1:0]   len_q;
	logic [HEAD_W-1:0]  head_q;

	// scores and table
	logic [CONF_W-1:0]  best_conf, best_conf_q;
	logic [PROTO_W-1:0] win_proto, win_proto_q;
	apd_entry_t         sess_mem_q [SESSIONS];
	apd_entry_t         rd_q;
	apd_entry_t         ent_new;
	logic [PROTO_W-1:0] res_proto;
	logic [SIDX_W-1:0]  idx;
	logic [SIDX_W-1:0]  clr_addr_q;

	// output register
	logic               out_valid_q;
	logic [PROTO_W-1:0] protocol_q;
	logic [CONF_W-1:0]  confidence_q;
	logic [DS_W-1:0]    detect_state_q;

	// capture the beat and reduce the session id by restoring subtraction
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			rem_q   <= session_id;
			div_q   <= ID_W'(DIV_INIT);
			step_q  <= STEP_W'(MOD_STEPS);
			hport_q <= direction ? source_port : dest_port;
			dir_q   <= direction;
			len_q   <= payload_size;
			head_q  <= payload_head;
		end else if (cmd.mod_step) begin
			if (rem_q >= div_q) begin
				rem_q <= rem_q - div_q;
			end
			div_q  <= div_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	assign idx = SIDX_W'(rem_q);

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	apd_probe u_probe (
		.head      (head_q),
		.len       (len_q),
		.dir       (dir_q),
		.hport     (hport_q),
		.cfg       (cfg),
		.best_conf (best_conf),
		.win_proto (win_proto)
	);

	// probe results register alongside the table read
	always_ff @(posedge clk) begin
		if (cmd.score_load) begin
			best_conf_q <= best_conf;
			win_proto_q <= win_proto;
		end
	end

	// session table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			sess_mem_q[clr_addr_q] <= '0;
		end else if (cmd.commit) begin
			sess_mem_q[idx] <= ent_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= sess_mem_q[idx];
		end
	end

	// entry update
	always_comb begin
		ent_new   = rd_q;
		res_proto = PROTO_UNKNOWN;
		if (len_q == '0) begin
			res_proto = PROTO_UNKNOWN;
		end else if (rd_q.st == DS_DONE && rd_q.conf >= CONF_DONE) begin
			res_proto = rd_q.proto;
		end else if (rd_q.attempts >= cfg.attempt_limit) begin
			ent_new.st = DS_FAILED;
		end else begin
			ent_new.attempts = rd_q.attempts + 1'b1;
			if (best_conf_q > rd_q.conf) begin
				ent_new.proto = win_proto_q;
				ent_new.conf  = best_conf_q;
				ent_new.st    = (best_conf_q >= CONF_DONE) ? DS_DONE : DS_PROGRESS;
			end
			res_proto = ent_new.proto;
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			protocol_q     <= res_proto;
			confidence_q   <= ent_new.conf;
			detect_state_q <= ent_new.st;
		end
	end

	assign out_valid    = out_valid_q;
	assign protocol     = protocol_q;
	assign confidence   = confidence_q;
	assign detect_state = detect_state_q;

	// status back to the controller
	assign sts.clr_last = (clr_addr_q == SIDX_W'(SESSIONS - 1));
	assign sts.mod_need = (MOD_STEPS != 0);
	assign sts.mod_last = (step_q == STEP_W'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// ===== sv/app_protocol_detector.sv =====
// application protocol detector
// input channel: one beat per packet (session id, ports, direction, length,
// first six payload bytes), taken when in_valid is high and in_stall is low.
// output channel: one beat per packet (protocol, confidence, detect_state),
// taken when out_valid is high and out_stall is low.
// configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// write only while no packet is in flight.
// processing: the input beat is registered, the 10-bit session id is folded
// into SESSIONS entries by N restoring-subtract steps (0 for SESSIONS >=
// 1024), the entry is read from the session table, scored and updated, and
// it is written back as the result is registered and out_valid rises.
// pacing: in_stall stays high until the previous packet has been written back.
// reset: control, configuration and output-valid registers return to their
// defaults; the session table is then cleared one entry per cycle, in_stall high.
// stall: a finished result waits in the output register; the next packet is
// still taken and worked up to the write-back, which waits for the slot.
`default_nettype none

module app_protocol_detector import apd_pkg::*; #(
	parameter int SESSIONS = SESSIONS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ID_W-1:0]       session_id,
	input  logic [PORT_W-1:0]     source_port,
	input  logic [PORT_W-1:0]     dest_port,
	input  logic                  direction,
	input  logic [LEN_W-1:0]      payload_size,
	input  logic [HEAD_W-1:0]     payload_head,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PROTO_W-1:0]    protocol,
	output logic [CONF_W-1:0]     confidence,
	output logic [DS_W-1:0]       detect_state,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	apd_cfg_t cfg;
	apd_cmd_t cmd;
	apd_sts_t sts;

	apd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	apd_dp #(
		.SESSIONS (SESSIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.session_id   (session_id),
		.source_port  (source_port),
		.dest_port    (dest_port),
		.direction    (direction),
		.payload_size (payload_size),
		.payload_head (payload_head),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.protocol     (protocol),
		.confidence   (confidence),
		.detect_state (detect_state)
	);

endmodule

`default_nettype wire

// ===== sv/apd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module apd_checker import apd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [PROTO_W-1:0] protocol,
	input  logic [CONF_W-1:0]  confidence,
	input  logic [DS_W-1:0]    detect_state
);

	// a stalled result beat holds
	`APD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(protocol) && $stable(confidence) && $stable(detect_state))

	// one packet at a time: the beat after an accepted one is stalled
	`APD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	// a done session always carries a high confidence
	`APD_ASSERT_SAME(a_done_conf, clk, arst_n, out_valid && detect_state == DS_DONE, confidence >= CONF_DONE)

	// an untouched session shows nothing
	`APD_ASSERT_SAME(a_none_clean, clk, arst_n, out_valid && detect_state == DS_NONE, confidence == '0 && protocol == PROTO_UNKNOWN)

	// in progress means some but not enough confidence
	`APD_ASSERT_SAME(a_prog_conf, clk, arst_n, out_valid && detect_state == DS_PROGRESS, confidence != '0 && confidence < CONF_DONE)

endmodule

bind app_protocol_detector apd_checker u_apd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.protocol     (protocol),
	.confidence   (confidence),
	.detect_state (detect_state)
);

`default_nettype wire

// ===== tb/apd_verdict_checker.sv =====
`timescale 1ns / 1ps

module apd_verdict_checker import apd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [ID_W-1:0]       session_id,
	input  logic [PORT_W-1:0]     source_port,
	input  logic [PORT_W-1:0]     dest_port,
	input  logic                  direction,
	input  logic [LEN_W-1:0]      payload_size,
	input  logic [HEAD_W-1:0]     payload_head,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [PROTO_W-1:0]    protocol,
	input  logic [CONF_W-1:0]     confidence,
	input  logic [DS_W-1:0]       detect_state,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    mismatches,
	output int                    checked
);

	// what one output beat should carry
	typedef struct packed {
		logic [PROTO_W-1:0] proto;
		logic [CONF_W-1:0]  conf;
		logic [DS_W-1:0]    st;
	} verdict_t;

	apd_entry_t sess_ctx [SESSIONS_DEFAULT];
	apd_cfg_t   regs;
	verdict_t   verdicts_due [$];
	int         n;

	// three ascii digits, the first one within lo..hi
	function automatic logic reply_code(input logic [HEAD_W-1:0] head,
			input logic [7:0] lo, input logic [7:0] hi);
		return head[47:40] >= lo && head[47:40] <= hi &&
			head[39:32] >= CH_0 && head[39:32] <= CH_9 &&
			head[31:24] >= CH_0 && head[31:24] <= CH_9;
	endfunction

	// confidence that one protocol's signature gives for this payload
	function automatic int signature_score(input int p, input logic [HEAD_W-1:0] head,
			input logic [LEN_W-1:0] len, input logic dir);
		logic [31:0] w4;
		logic [15:0] qd;
		w4 = head[47:16];
		qd = head[15:0];
		case (p)
		PROTO_HTTP: begin
			if (len >= 4 && (w4 == SIG_GET || w4 == SIG_POST ||
					w4 == SIG_HEAD || w4 == SIG_PUT))
				return int'(CONF_STRONG);
			if (len >= 5 && head[47:8] == SIG_HTTP)
				return int'(CONF_STRONG);
		end
		PROTO_FTP: begin
			if (dir && len >= 3 && reply_code(head, CH_1, CH_5))
				return int'(CONF_REPLY);
			if (!dir && len >= 4 && (w4 == SIG_USER || w4 == SIG_PASS || w4 == SIG_LIST))
				return int'(CONF_CMD);
		end
		PROTO_SMTP: begin
			if (len >= 4) begin
				if (!dir && (w4 == SIG_HELO || w4 == SIG_EHLO ||
						w4 == SIG_MAIL || w4 == SIG_RCPT))
					return int'(CONF_CMD);
				if (dir && reply_code(head, CH_2, CH_5))
					return int'(CONF_REPLY);
			end
		end
		PROTO_TLS: begin
			if (len >= 3 && head[39:32] == TLS_MAJOR && head[31:24] <= TLS_MINOR_MAX) begin
				if (head[47:40] == TLS_HANDSHAKE)
					return int'(CONF_TLS_HS);
				if (head[47:40] == TLS_APPDATA)
					return int'(CONF_TLS_APP);
			end
		end
		PROTO_SSH: begin
			if (len >= 4 && w4 == SIG_SSH)
				return int'(CONF_STRONG);
		end
		default: begin
			if (len >= DNS_MIN_LEN && qd != 16'd0 && qd <= DNS_QD_MAX)
				return int'(CONF_DNS);
		end
		endcase
		return 0;
	endfunction

	// protocol whose register matches the port; later registers win
	function automatic logic [PROTO_W-1:0] hint_owner(input logic [PORT_W-1:0] port);
		if (port == '0)
			return PROTO_UNKNOWN;
		if (port == regs.smtp_port)
			return PROTO_SMTP;
		if (port == regs.ftp_port)
			return PROTO_FTP;
		if (port == regs.dns_port)
			return PROTO_DNS;
		if (port == regs.ssh_port)
			return PROTO_SSH;
		if (port == regs.tls_port)
			return PROTO_TLS;
		if (port == regs.http_port)
			return PROTO_HTTP;
		return PROTO_UNKNOWN;
	endfunction

	// classify one packet and update its session entry
	function automatic verdict_t classify_packet(input logic [ID_W-1:0] sid,
			input logic [PORT_W-1:0] sport, input logic [PORT_W-1:0] dport,
			input logic dir, input logic [LEN_W-1:0] len, input logic [HEAD_W-1:0] head);
		apd_entry_t         e;
		verdict_t           v;
		logic [PROTO_W-1:0] hint;
		logic [PROTO_W-1:0] best_p;
		int                 idx;
		int                 p;
		int                 score;
		int                 best;
		idx = sid % SESSIONS_DEFAULT;
		e = sess_ctx[idx];
		if (len == '0) begin
			v.proto = PROTO_UNKNOWN;
		end else if (e.st == DS_DONE && e.conf >= CONF_DONE) begin
			v.proto = e.proto;
		end else if (e.attempts >= regs.attempt_limit) begin
			e.st = DS_FAILED;
			v.proto = PROTO_UNKNOWN;
		end else begin
			hint = hint_owner(dir ? sport : dport);
			e.attempts = e.attempts + 1'b1;
			best = 0;
			best_p = PROTO_UNKNOWN;
			for (p = int'(PROTO_HTTP); p <= PROTO_DNS; p++) begin
				score = signature_score(p, head, len, dir);
				if (p == hint) begin
					score = score + HINT_BONUS;
					if (score > CONF_MAX)
						score = int'(CONF_MAX);
				end
				if (score > best) begin
					best = score;
					best_p = p[PROTO_W-1:0];
				end
			end
			// only a better score replaces what the session holds
			if (best > e.conf) begin
				e.proto = best_p;
				e.conf = best[CONF_W-1:0];
				e.st = (best >= CONF_DONE) ? DS_DONE : DS_PROGRESS;
			end
			v.proto = e.proto;
		end
		sess_ctx[idx] = e;
		v.conf = e.conf;
		v.st = e.st;
		return v;
	endfunction

	// watch register writes, packet beats and result beats
	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			for (n = 0; n < SESSIONS_DEFAULT; n++)
				sess_ctx[n] = '0;
			regs.http_port = HTTP_PORT_RST;
			regs.tls_port = TLS_PORT_RST;
			regs.ssh_port = SSH_PORT_RST;
			regs.dns_port = DNS_PORT_RST;
			regs.ftp_port = FTP_PORT_RST;
			regs.smtp_port = SMTP_PORT_RST;
			regs.attempt_limit = ATTEMPT_LIMIT_RST;
			verdicts_due.delete();
			mismatches = 0;
			checked = 0;
			pending <= 0;
		end else begin
			// register write, out of range indexes do nothing
			if (cfg_we) begin
				case (cfg_index)
				REG_HTTP_PORT: regs.http_port = cfg_data;
				REG_TLS_PORT: regs.tls_port = cfg_data;
				REG_SSH_PORT: regs.ssh_port = cfg_data;
				REG_DNS_PORT: regs.dns_port = cfg_data;
				REG_FTP_PORT: regs.ftp_port = cfg_data;
				REG_SMTP_PORT: regs.smtp_port = cfg_data;
				REG_ATTEMPT_LIMIT: regs.attempt_limit = cfg_data[ATT_W-1:0];
				default: ;
				endcase
			end
			// result beat against the oldest expectation
			if (out_valid && !out_stall) begin
				got.proto = protocol;
				got.conf = confidence;
				got.st = detect_state;
				if (verdicts_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat: protocol %0d confidence %0d state %0d",
						$time, got.proto, got.conf, got.st);
				end else begin
					want = verdicts_due.pop_front();
					checked++;
					if (got.proto !== want.proto || got.conf !== want.conf ||
							got.st !== want.st) begin
						mismatches++;
						$display("%0t: expected protocol %0d confidence %0d state %0d, got %0d %0d %0d",
							$time, want.proto, want.conf, want.st, got.proto, got.conf, got.st);
					end
				end
			end
			// packet beat
			if (in_valid && !in_stall)
				verdicts_due.push_back(classify_packet(session_id, source_port, dest_port,
					direction, payload_size, payload_head));
			pending <= verdicts_due.size();
		end
	end

endmodule

// ===== tb/tb_app_protocol_detector.sv =====
`timescale 1ns / 1ps

module tb_app_protocol_detector;
	import apd_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 153;
	localparam int DRAIN         = 8;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// kinds of payload head the generator builds
	typedef enum int {
		HK_GET, HK_POST, HK_HEAD, HK_PUT, HK_HTTP, HK_USER, HK_PASS, HK_LIST,
		HK_REPLY, HK_HELO, HK_EHLO, HK_MAIL, HK_RCPT, HK_TLS, HK_SSH, HK_DNS,
		HK_NEAR, HK_NOISE
	} head_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [ID_W-1:0]       session_id;
	logic [PORT_W-1:0]     source_port;
	logic [PORT_W-1:0]     dest_port;
	logic                  direction;
	logic [LEN_W-1:0]      payload_size;
	logic [HEAD_W-1:0]     payload_head;
	logic                  out_valid;
	logic                  out_stall;
	logic [PROTO_W-1:0]    protocol;
	logic [CONF_W-1:0]     confidence;
	logic [DS_W-1:0]       detect_state;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int       pending;
	int       mismatches;
	int       checked;
	int       packets_sent;
	int       settings_used;
	int       cycles;
	bit       calm;
	apd_cfg_t cur_cfg;

	app_protocol_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.session_id   (session_id),
		.source_port  (source_port),
		.dest_port    (dest_port),
		.direction    (direction),
		.payload_size (payload_size),
		.payload_head (payload_head),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.protocol     (protocol),
		.confidence   (confidence),
		.detect_state (detect_state),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	apd_verdict_checker verdict_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.session_id   (session_id),
		.source_port  (source_port),
		.dest_port    (dest_port),
		.direction    (direction),
		.payload_size (payload_size),
		.payload_head (payload_head),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.protocol     (protocol),
		.confidence   (confidence),
		.detect_state (detect_state),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.mismatches   (mismatches),
		.checked      (checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic apd_cfg_t reset_config();
		apd_cfg_t c;
		c.http_port = HTTP_PORT_RST;
		c.tls_port = TLS_PORT_RST;
		c.ssh_port = SSH_PORT_RST;
		c.dns_port = DNS_PORT_RST;
		c.ftp_port = FTP_PORT_RST;
		c.smtp_port = SMTP_PORT_RST;
		c.attempt_limit = ATTEMPT_LIMIT_RST;
		return c;
	endfunction

	// one port value for a settings style
	function automatic logic [PORT_W-1:0] port_for_mode(input int mode);
		logic [31:0] r;
		r = $urandom;
		case (mode)
		1: return r[PORT_W-1:0];
		2: return '0;
		3: return '1;
		default: begin
			// small set so that registers often share a port
			case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return HTTP_PORT_RST;
			3: return TLS_PORT_RST;
			default: return r[PORT_W-1:0];
			endcase
		end
		endcase
	endfunction

	function automatic apd_cfg_t random_config(input int k);
		apd_cfg_t c;
		int       mode;
		c = reset_config();
		mode = k % 5;
		if (mode != 0) begin
			c.http_port = port_for_mode(mode);
			c.tls_port = port_for_mode(mode);
			c.ssh_port = port_for_mode(mode);
			c.dns_port = port_for_mode(mode);
			c.ftp_port = port_for_mode(mode);
			c.smtp_port = port_for_mode(mode);
		end
		if (k == 0)
			c.attempt_limit = '1;
		else if (k == 1)
			c.attempt_limit = '0;
		else if ($urandom_range(0, 3) == 0)
			c.attempt_limit = ATT_W'($urandom_range(0, 15));
		else
			c.attempt_limit = ATT_W'($urandom_range(1, 4));
		return c;
	endfunction

	// hint port: mostly one of the programmed ports
	function automatic logic [PORT_W-1:0] pick_port();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
		0: return cur_cfg.http_port;
		1: return cur_cfg.tls_port;
		2: return cur_cfg.ssh_port;
		3: return cur_cfg.dns_port;
		4: return cur_cfg.ftp_port;
		5: return cur_cfg.smtp_port;
		6: return '0;
		7: return '1;
		default: return r[PORT_W-1:0];
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 11))
		0: return '0;
		1: return LEN_W'($urandom_range(1, 5));
		2: return LEN_W'($urandom_range(11, 13));
		3: return '1;
		4: return r[LEN_W-1:0];
		default: return LEN_W'($urandom_range(4, 1500));
		endcase
	endfunction

	// byte around the ascii digit range
	function automatic logic [7:0] digit_ish();
		return 8'($urandom_range(CH_0 - 8'd1, CH_9 + 8'd1));
	endfunction

	// payload head of a given kind over random filler
	function automatic logic [HEAD_W-1:0] make_head(input int kind);
		logic [63:0]       r;
		logic [HEAD_W-1:0] h;
		r = {$urandom, $urandom};
		h = r[HEAD_W-1:0];
		case (kind)
		HK_GET: h[47:16] = SIG_GET;
		HK_POST: h[47:16] = SIG_POST;
		HK_HEAD: h[47:16] = SIG_HEAD;
		HK_PUT: h[47:16] = SIG_PUT;
		HK_HTTP: h[47:8] = SIG_HTTP;
		HK_USER: h[47:16] = SIG_USER;
		HK_PASS: h[47:16] = SIG_PASS;
		HK_LIST: h[47:16] = SIG_LIST;
		HK_REPLY: begin
			h[47:40] = digit_ish();
			h[39:32] = digit_ish();
			h[31:24] = digit_ish();
		end
		HK_HELO: h[47:16] = SIG_HELO;
		HK_EHLO: h[47:16] = SIG_EHLO;
		HK_MAIL: h[47:16] = SIG_MAIL;
		HK_RCPT: h[47:16] = SIG_RCPT;
		HK_TLS: begin
			h[47:40] = $urandom_range(0, 1) ? TLS_HANDSHAKE : TLS_APPDATA;
			h[39:32] = $urandom_range(0, 7) ? TLS_MAJOR : r[63:56];
			h[31:24] = 8'($urandom_range(0, 5));
		end
		HK_SSH: h[47:16] = SIG_SSH;
		HK_DNS: begin
			if ($urandom_range(0, 3) != 0)
				h[15:0] = 16'($urandom_range(0, 11));
		end
		HK_NEAR: h = make_head($urandom_range(HK_GET, HK_DNS)) ^
			(48'd1 << $urandom_range(0, HEAD_W - 1));
		default: ;
		endcase
		return h;
	endfunction

	// present one packet beat and hold it until taken
	task automatic send_packet(input logic [ID_W-1:0] sid, input logic [PORT_W-1:0] sport,
			input logic [PORT_W-1:0] dport, input logic dir, input logic [LEN_W-1:0] len,
			input logic [HEAD_W-1:0] head);
		int gap;
		gap = calm ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		session_id <= sid;
		source_port <= sport;
		dest_port <= dport;
		direction <= dir;
		payload_size <= len;
		payload_head <= head;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		packets_sent++;
	endtask

	// random packet, mostly on a small pool of sessions so they progress
	task automatic send_random(input logic [ID_W-1:0] hot_base);
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 99) < 85)
			r = hot_base + $urandom_range(0, 11);
		send_packet(r[ID_W-1:0], pick_port(), pick_port(), 1'($urandom_range(0, 1)), pick_len(),
			make_head($urandom_range(HK_GET, HK_NOISE)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// drain the block, then program every register
	task automatic apply_config(input apd_cfg_t c);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		write_reg(REG_HTTP_PORT, c.http_port);
		write_reg(REG_TLS_PORT, c.tls_port);
		write_reg(REG_SSH_PORT, c.ssh_port);
		write_reg(REG_DNS_PORT, c.dns_port);
		write_reg(REG_FTP_PORT, c.ftp_port);
		write_reg(REG_SMTP_PORT, c.smtp_port);
		write_reg(REG_ATTEMPT_LIMIT, {junk[CFG_DATA_W-1:ATT_W], c.attempt_limit});
		write_reg(REG_UNUSED, junk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
		settings_used++;
	endtask

	// result side stalls
	initial begin : sink_pacing
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(0, 2) == 0)
					hold = pause_len();
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		apd_cfg_t    c;
		logic [31:0] r;
		int          k;
		int          j;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		session_id <= '0;
		source_port <= '0;
		dest_port <= '0;
		direction <= 1'b0;
		payload_size <= '0;
		payload_head <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		calm = 1'b0;
		packets_sent = 0;
		settings_used = 1;
		cur_cfg = reset_config();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each probe, the hint, ties and the session rules
		send_packet(10'd0, 16'd1000, HTTP_PORT_RST, 1'b0, 16'd0, {SIG_GET, 16'h0});
		send_packet(10'd1, 16'd1000, HTTP_PORT_RST, 1'b0, 16'd4, {SIG_GET, 16'h0});
		send_packet(10'd1, 16'd1000, TLS_PORT_RST, 1'b0, 16'd3,
			{TLS_HANDSHAKE, TLS_MAJOR, TLS_MINOR_MAX, 24'h0});
		send_packet(10'd2, 16'd1000, 16'd1234, 1'b0, 16'd3, {SIG_POST, 16'h0});
		send_packet(10'd3, 16'd1000, 16'd0, 1'b0, 16'd4, {SIG_HEAD, 16'hFFFF});
		send_packet(10'd4, 16'hFFFF, 16'd1000, 1'b1, 16'hFFFF, {SIG_PUT, 16'h0});
		send_packet(10'd5, 16'd1000, 16'd1000, 1'b0, 16'd4, {SIG_HTTP, 8'h0});
		send_packet(10'd6, 16'd1000, TLS_PORT_RST, 1'b0, 16'd5, {SIG_HTTP, 8'h0});
		send_packet(10'd7, FTP_PORT_RST, 16'd1000, 1'b1, 16'd3, {CH_2, CH_2, CH_0, 24'h0});
		send_packet(10'd8, 16'd1000, FTP_PORT_RST, 1'b0, 16'd4, {SIG_USER, 16'h0});
		send_packet(10'd9, 16'd1000, SMTP_PORT_RST, 1'b0, 16'd4, {SIG_HELO, 16'h0});
		send_packet(10'd10, SMTP_PORT_RST, 16'd1000, 1'b1, 16'd4, {CH_2, CH_5, CH_0, 24'h0});
		send_packet(10'd11, 16'd9999, 16'd1000, 1'b1, 16'd4, {CH_2, CH_5, CH_0, 24'h0});
		send_packet(10'd11, 16'd9999, 16'd1000, 1'b1, 16'd4, {CH_2, CH_5, CH_0, 24'h0});
		send_packet(10'd12, 16'd1000, TLS_PORT_RST, 1'b0, 16'd3,
			{TLS_HANDSHAKE, TLS_MAJOR, TLS_MINOR_MAX, 24'h0});
		send_packet(10'd13, 16'd1000, 16'd0, 1'b0, 16'd3, {TLS_APPDATA, TLS_MAJOR, 8'h01, 24'h0});
		send_packet(10'd14, 16'd1000, 16'd1000, 1'b0, 16'd3,
			{TLS_HANDSHAKE, TLS_MAJOR, TLS_MINOR_MAX + 8'd1, 24'h0});
		send_packet(10'd15, 16'd1000, SSH_PORT_RST, 1'b0, 16'd4, {SIG_SSH, 16'h0});
		send_packet(10'd16, 16'd1000, DNS_PORT_RST, 1'b0, 16'd12, {32'h0, 16'd1});
		send_packet(10'd17, 16'd7, 16'd1000, 1'b1, 16'd12, {32'h0, DNS_QD_MAX});
		send_packet(10'd18, 16'd1000, 16'd1000, 1'b0, 16'd12, {32'h0, DNS_QD_MAX + 16'd1});
		send_packet(10'd19, 16'd1000, DNS_PORT_RST, 1'b0, 16'd5, 48'h0);
		send_packet(10'd1023, 16'd1000, 16'd1000, 1'b0, 16'd4, {SIG_SSH, 16'h0});

		// shared ports, disabled hints and an attempt limit of one
		c = reset_config();
		c.http_port = '1;
		c.tls_port = '1;
		c.ssh_port = '0;
		c.dns_port = '0;
		c.ftp_port = 16'd1;
		c.smtp_port = '1;
		c.attempt_limit = 4'd1;
		apply_config(c);
		send_packet(10'd30, 16'd1000, 16'hFFFF, 1'b0, 16'd4, {SIG_GET, 16'h0});
		send_packet(10'd31, 16'd1000, 16'hFFFF, 1'b0, 16'd8, 48'h0);
		send_packet(10'd31, 16'd1000, 16'hFFFF, 1'b0, 16'd8, 48'h0);
		send_packet(10'd31, 16'd1000, 16'hFFFF, 1'b0, 16'd0, 48'h0);

		// random phases, each with its own settings and session pool
		for (k = 0; k < RANDOM_PHASES; k++) begin
			apply_config(random_config(k));
			calm = (k % 4 == 2);
			r = $urandom;
			for (j = 0; j < PHASE_ITEMS; j++)
				send_random(r[ID_W-1:0]);
		end
		calm = 1'b0;

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d packets sent under %0d register settings, %0d results compared",
			packets_sent, settings_used, checked);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/apd_pkg.sv
sv/apd_probe.sv
sv/apd_regs.sv
sv/apd_ctrl.sv
sv/apd_dp.sv
sv/app_protocol_detector.sv
sv/apd_checker.sv
tb/apd_verdict_checker.sv
tb/tb_app_protocol_detector.sv
